[hdl/sffp_pkg.sv]
// Package for the shape first-fit placer: sizes, widths and shared types.
// Depends on nothing; used by sffp_if, sffp_rotator and the top level in hdl.
package sffp_pkg;

  localparam int BoardSize = 64;
  localparam int ShapeSize = 16;
  localparam int NumOrient = 4;

  localparam int RowW   = $clog2(BoardSize);
  localparam int SRowW  = $clog2(ShapeSize);
  localparam int SizeW  = 5;
  localparam int CfgW   = 7;
  localparam int CntW   = 13;
  localparam int AddrW  = 2;

  localparam logic [AddrW-1:0] RegBoardRows = 2'd0;
  localparam logic [AddrW-1:0] RegBoardCols = 2'd1;

  typedef logic [ShapeSize-1:0] srow_t;
  typedef logic [BoardSize-1:0] brow_t;

  // Count set bits of a shape row.
  function automatic logic [SRowW:0] popcount16(input srow_t v);
    logic [SRowW:0] n;
    n = '0;
    for (int b = 0; b < ShapeSize; b++) n = n + (SRowW+1)'(v[b]);
    return n;
  endfunction

endpackage

[hdl/sffp_if.sv]
// Valid/ready channel interface for shape row requests and placement results.
// Depends on sffp_pkg.
interface sffp_in_if;
  logic                         valid;
  logic                         ready;
  logic [sffp_pkg::SizeW-1:0]   shape_height;
  logic [sffp_pkg::SizeW-1:0]   shape_width;
  logic [15:0]                  row_bits;
  logic                         row_last;
  modport source (output valid, shape_height, shape_width, row_bits, row_last, input ready);
  modport sink   (input valid, shape_height, shape_width, row_bits, row_last, output ready);
endinterface

interface sffp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        placed;
  logic [1:0]                  rotation;
  logic [5:0]                  top;
  logic [5:0]                  left;
  logic [sffp_pkg::CntW-1:0]   occupied_count;
  modport source (output valid, placed, rotation, top, left, occupied_count, input ready);
  modport sink   (input valid, placed, rotation, top, left, occupied_count, output ready);
endinterface

[hdl/sffp_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
module sffp_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word when enabled; always read the addressed word
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hdl/sffp_rotator.sv]
// Quarter-turn clockwise rotation of the working shape, one output row per cycle.
// Depends on sffp_pkg.
module sffp_rotator (
  input  sffp_pkg::srow_t           src_i [sffp_pkg::ShapeSize],
  input  logic [sffp_pkg::SizeW-1:0] h_i,
  input  logic [sffp_pkg::SRowW-1:0] col_i,
  output sffp_pkg::srow_t           row_o
);

  // New row j takes column j of old rows, old row i landing at bit h-1-i
  always_comb begin
    row_o = '0;
    for (int i = 0; i < sffp_pkg::ShapeSize; i++) begin
      if ((sffp_pkg::SizeW)'(i) < h_i && src_i[i][col_i])
        row_o[sffp_pkg::SRowW'(h_i - (sffp_pkg::SizeW)'(i) - 1)] = 1'b1;
    end
  end

endmodule

[hdl/shape_first_fit_placer_unit.sv]
// Top level of the shape first-fit placer: sequencer, board RAM, APB registers.
// Depends on sffp_pkg, sffp_if, sffp_ram, sffp_rotator.
//
//  channel | dir | handshake     | payload
//  in_req  | in  | valid/ready   | shape_height, shape_width, row_bits, row_last
//  out_res | out | valid/ready   | placed, rotation, top, left, occupied_count
//  cfg     | in  | APB psel/pen  | board_rows (0x0), board_cols (0x4)
//
// A row request that is not last is only stored. A last row runs the search:
// each offset tried takes a bounds check, then a read and a compare per shape
// row up to the first colliding row; an offset row whose columns do not fit
// takes only the bounds check, a rotation rebuilds the shape row by row, and
// marking reads and writes each shape row through the single board RAM port.
// After reset the board RAM is cleared, one row a cycle, and no request is
// accepted until it is done. A finished result holds until the sink takes it.
module shape_first_fit_placer_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  sffp_in_if.sink        in_req,
  sffp_out_if.source     out_res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int BS = sffp_pkg::BoardSize;
  localparam int SS = sffp_pkg::ShapeSize;
  localparam int RW = sffp_pkg::RowW;
  localparam int SW = sffp_pkg::SRowW;
  localparam int ZW = sffp_pkg::SizeW;

  typedef enum logic [3:0] {
    StClear, StIdle, StRot, StCheckRd, StCheck, StNext, StMarkRd, StMarkWr, StOut
  } state_e;

  state_e state_q;
  logic [sffp_pkg::CfgW-1:0] rows_q, cols_q;
  sffp_pkg::srow_t store_q [SS];
  sffp_pkg::srow_t shp_q [SS];
  logic [SW-1:0]  load_q;
  logic [ZW-1:0]  h_q, w_q;
  logic [RW:0]    nr_q, nc_q;
  logic [1:0]     k_q;
  logic [RW:0]    ti_q, tj_q;
  logic [SW:0]    r_q;
  logic [sffp_pkg::CntW-1:0] total_q;
  logic           o_valid_q, o_placed_q;
  logic [1:0]     o_rot_q;
  logic [5:0]     o_top_q, o_left_q;

  // APB register access
  assign pready = 1'b1;
  logic [sffp_pkg::AddrW-1:0] reg_idx;
  assign reg_idx = paddr[2 +: sffp_pkg::AddrW-1] == 1'b1 ? sffp_pkg::RegBoardCols
                                                         : sffp_pkg::RegBoardRows;
  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'b0) prdata[sffp_pkg::CfgW-1:0] = rows_q;
    else                  prdata[sffp_pkg::CfgW-1:0] = cols_q;
  end

  // Board RAM port
  logic        ram_we;
  logic [RW-1:0] ram_addr;
  sffp_pkg::brow_t ram_wdata, ram_rdata;

  sffp_ram #(.Width(BS), .Depth(BS)) u_board (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // Rotation of the working shape, one new row per cycle
  sffp_pkg::srow_t rot_row;
  sffp_rotator u_rot (.src_i(shp_q), .h_i(h_q), .col_i(r_q[SW-1:0]), .row_o(rot_row));
  sffp_pkg::srow_t rot_buf_q [SS];

  // Current shape row shifted to the offset
  sffp_pkg::brow_t shifted;
  assign shifted = sffp_pkg::brow_t'(shp_q[r_q[SW-1:0]]) << tj_q[RW-1:0];

  logic [RW:0] row_sum;
  assign row_sum = ti_q + (RW+1)'(r_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | shifted;
    ram_addr  = row_sum[RW-1:0];
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = tj_q[RW-1:0];
      end
      StMarkWr: ram_we = 1'b1;
      default: ;
    endcase
  end

  logic fits_h, fits_w;
  assign fits_h = (RW+1)'(ti_q) + (RW+1)'(h_q) <= nr_q;
  assign fits_w = (RW+1)'(tj_q) + (RW+1)'(w_q) <= nc_q;

  assign in_req.ready = (state_q == StIdle) && !o_valid_q;
  assign out_res.valid = o_valid_q;
  assign out_res.placed = o_placed_q;
  assign out_res.rotation = o_rot_q;
  assign out_res.top = o_top_q;
  assign out_res.left = o_left_q;
  assign out_res.occupied_count = total_q;

  logic [ZW-1:0] hin, win;
  assign hin = in_req.shape_height > ZW'(SS) ? ZW'(SS) : in_req.shape_height;
  assign win = in_req.shape_width  > ZW'(SS) ? ZW'(SS) : in_req.shape_width;

  // Store shape rows (no reset: undefined until written)
  always_ff @(posedge clk_i) begin
    if (in_req.valid && in_req.ready) store_q[load_q] <= in_req.row_bits;
    if (state_q == StRot) rot_buf_q[r_q[SW-1:0]] <= rot_row;
    if (state_q == StIdle && in_req.valid && in_req.ready && in_req.row_last) begin
      for (int r = 0; r < SS; r++) begin
        shp_q[r] <= (ZW'(r) < hin)
                    ? ((r == int'(load_q) ? in_req.row_bits : store_q[r])
                       & sffp_pkg::srow_t'((17'd1 << win) - 17'd1))
                    : '0;
      end
    end else if (state_q == StRot && r_q == (SW+1)'(SS - 1)) begin
      for (int r = 0; r < SS - 1; r++) shp_q[r] <= rot_buf_q[r];
      shp_q[SS-1] <= rot_row;
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      rows_q <= sffp_pkg::CfgW'(BS); cols_q <= sffp_pkg::CfgW'(BS);
      load_q <= '0; h_q <= '0; w_q <= '0; nr_q <= '0; nc_q <= '0;
      k_q <= '0; ti_q <= '0; tj_q <= '0; r_q <= '0; total_q <= '0;
      o_valid_q <= 1'b0; o_placed_q <= 1'b0; o_rot_q <= '0; o_top_q <= '0;
      o_left_q <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (reg_idx == sffp_pkg::RegBoardRows) rows_q <= pwdata[sffp_pkg::CfgW-1:0];
        else                                   cols_q <= pwdata[sffp_pkg::CfgW-1:0];
      end
      if (o_valid_q && out_res.ready) o_valid_q <= 1'b0;
      case (state_q)
        StClear: begin
          tj_q <= tj_q + 1'b1;
          if (tj_q == (RW+1)'(BS - 1)) begin
            tj_q <= '0;
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_req.valid && in_req.ready) begin
            if (!in_req.row_last) begin
              if (load_q != SW'(SS - 1)) load_q <= load_q + 1'b1;
            end else begin
              load_q <= '0;
              h_q <= hin; w_q <= win;
              nr_q <= rows_q > sffp_pkg::CfgW'(BS) ? (RW+1)'(BS) : (RW+1)'(rows_q);
              nc_q <= cols_q > sffp_pkg::CfgW'(BS) ? (RW+1)'(BS) : (RW+1)'(cols_q);
              k_q <= '0; ti_q <= '0; tj_q <= '0; r_q <= '0;
              state_q <= StNext;
            end
          end
        end
        // Validate offset; start a row check, move on, rotate, or give the result
        StNext: begin
          r_q <= '0;
          if (!fits_h) begin
            if (k_q == 2'd3) begin
              o_valid_q <= 1'b1; o_placed_q <= 1'b0; o_rot_q <= '0;
              o_top_q <= '0; o_left_q <= '0;
              state_q <= StOut;
            end else begin
              state_q <= StRot;
            end
          end else if (!fits_w) begin
            tj_q <= '0; ti_q <= ti_q + 1'b1;
          end else if (h_q == '0) begin
            o_valid_q <= 1'b1; o_placed_q <= 1'b1; o_rot_q <= k_q;
            o_top_q <= ti_q[5:0]; o_left_q <= tj_q[5:0];
            state_q <= StOut;
          end else begin
            state_q <= StCheckRd;
          end
        end
        StCheckRd: state_q <= StCheck;
        StCheck: begin
          if ((ram_rdata & shifted) != '0) begin
            tj_q <= tj_q + 1'b1;
            state_q <= StNext;
          end else if (r_q + 1'b1 == (SW+1)'(h_q)) begin
            r_q <= '0;
            state_q <= StMarkRd;
          end else begin
            r_q <= r_q + 1'b1;
            state_q <= StCheckRd;
          end
        end
        StMarkRd: state_q <= StMarkWr;
        StMarkWr: begin
          total_q <= total_q + sffp_pkg::CntW'(sffp_pkg::popcount16(shp_q[r_q[SW-1:0]]));
          if (r_q + 1'b1 == (SW+1)'(h_q)) begin
            o_valid_q <= 1'b1; o_placed_q <= 1'b1; o_rot_q <= k_q;
            o_top_q <= ti_q[5:0]; o_left_q <= tj_q[5:0];
            state_q <= StOut;
          end else begin
            r_q <= r_q + 1'b1;
            state_q <= StMarkRd;
          end
        end
        // Build rotated rows into the buffer, then swap sizes
        StRot: begin
          r_q <= r_q + 1'b1;
          if (r_q == (SW+1)'(SS - 1)) begin
            h_q <= w_q; w_q <= h_q;
            k_q <= k_q + 1'b1;
            ti_q <= '0; tj_q <= '0; r_q <= '0;
            state_q <= StNext;
          end
        end
        StOut: if (!o_valid_q || out_res.ready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[dv/tb_shape_first_fit_placer_unit.sv]
// Testbench for shape_first_fit_placer_unit: first-fit shape placement with rotation.
// Depends on sffp_pkg, sffp_if and the placer RTL; predicts every placement internally.
`timescale 1ns / 100ps

module tb_shape_first_fit_placer_unit;

  localparam int BoardSize = sffp_pkg::BoardSize;
  localparam int ShapeSize = sffp_pkg::ShapeSize;
  localparam int NumOrient = sffp_pkg::NumOrient;
  localparam int SizeW     = sffp_pkg::SizeW;
  localparam int CntW      = sffp_pkg::CntW;
  localparam int AddrW     = sffp_pkg::AddrW;
  localparam logic [AddrW-1:0] RegBoardRows = sffp_pkg::RegBoardRows;
  localparam logic [AddrW-1:0] RegBoardCols = sffp_pkg::RegBoardCols;

  typedef sffp_pkg::srow_t srow_t;
  typedef sffp_pkg::brow_t brow_t;

  localparam int WatchLimit = 1500000;
  localparam int LongHold   = 2000;
  localparam int DrainWait  = 100;

  typedef struct packed {
    logic            placed;
    logic [1:0]      rotation;
    logic [5:0]      top;
    logic [5:0]      left;
    logic [CntW-1:0] occupied_count;
  } placement_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sffp_in_if  in_req ();
  sffp_out_if out_res ();

  shape_first_fit_placer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_req),
    .out_res (out_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the block state
  brow_t           occ_map [BoardSize];
  srow_t           mask_rows [ShapeSize];
  int unsigned     next_row;
  logic [CntW-1:0] cells_used;
  int unsigned     rows_limit;
  int unsigned     cols_limit;

  placement_t placement_q[$];
  int         error_count;
  int         rows_sent;
  bit         idle_en;
  bit         long_hold;

  always #1 clk_i = ~clk_i;

  // Search all orientations for the first free offset and mark it
  function automatic placement_t place_shape(input logic [SizeW-1:0] hgt,
                                             input logic [SizeW-1:0] wid);
    srow_t       shp [ShapeSize];
    srow_t       nxt [ShapeSize];
    int unsigned h, w, nr, nc, t;
    bit          ok;
    placement_t  res;
    h  = (hgt > ShapeSize) ? ShapeSize : hgt;
    w  = (wid > ShapeSize) ? ShapeSize : wid;
    nr = (rows_limit > BoardSize) ? BoardSize : rows_limit;
    nc = (cols_limit > BoardSize) ? BoardSize : cols_limit;
    for (int r = 0; r < ShapeSize; r++)
      shp[r] = (r < h) ? (mask_rows[r] & srow_t'((32'd1 << w) - 1)) : '0;
    for (int k = 0; k < NumOrient; k++) begin
      for (int i = 0; i + h <= nr; i++) begin
        for (int j = 0; j + w <= nc; j++) begin
          ok = 1'b1;
          for (int r = 0; r < h; r++)
            if (((brow_t'(shp[r]) << j) & occ_map[i+r]) != '0) ok = 1'b0;
          if (ok) begin
            for (int r = 0; r < h; r++) begin
              cells_used = cells_used + CntW'($countones(brow_t'(shp[r]) << j));
              occ_map[i+r] = occ_map[i+r] | (brow_t'(shp[r]) << j);
            end
            res.placed = 1'b1;
            res.rotation = 2'(k);
            res.top = 6'(i);
            res.left = 6'(j);
            res.occupied_count = cells_used;
            return res;
          end
        end
      end
      // quarter turn clockwise: (i,j) -> (j, h-1-i)
      for (int r = 0; r < ShapeSize; r++) nxt[r] = '0;
      for (int i = 0; i < h; i++)
        for (int j = 0; j < w; j++)
          if (shp[i][j]) nxt[j][h-1-i] = 1'b1;
      shp = nxt;
      t = h;
      h = w;
      w = t;
    end
    res = '0;
    res.occupied_count = cells_used;
    return res;
  endfunction

  // Offer one row request, then model it once it is taken
  task automatic send_row(input logic [SizeW-1:0] hgt, input logic [SizeW-1:0] wid,
                          input srow_t bits, input logic last);
    placement_t pred;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_req.valid        <= 1'b1;
    in_req.shape_height <= hgt;
    in_req.shape_width  <= wid;
    in_req.row_bits     <= bits;
    in_req.row_last     <= last;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    rows_sent++;
    mask_rows[next_row] = bits;
    if (!last) begin
      if (next_row < ShapeSize - 1) next_row++;
    end else begin
      next_row = 0;
      pred = place_shape(hgt, wid);
      placement_q = {placement_q, pred};
    end
  endtask

  function automatic srow_t pick_bits(input int density);
    case (density)
      0: return '0;
      1: return srow_t'($urandom & $urandom & $urandom);
      2: return srow_t'($urandom);
      default: return '1;
    endcase
  endfunction

  // Load a whole mask; always at least one row and at least the clamped height
  task automatic send_shape(input logic [SizeW-1:0] hgt, input logic [SizeW-1:0] wid,
                            input int density, input int extra);
    int n;
    n = (hgt > ShapeSize) ? ShapeSize : hgt;
    if (n == 0) n = 1;
    n = n + extra;
    for (int r = 0; r < n; r++) send_row(hgt, wid, pick_bits(density), r == n - 1);
  endtask

  task automatic send_random_shape(input int max_side);
    logic [SizeW-1:0] hgt, wid;
    hgt = ($urandom_range(0, 15) == 0) ? SizeW'($urandom_range(0, 31))
                                       : SizeW'($urandom_range(1, max_side));
    wid = ($urandom_range(0, 15) == 0) ? SizeW'($urandom_range(0, 31))
                                       : SizeW'($urandom_range(1, max_side));
    send_shape(hgt, wid, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3),
               $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0);
  endtask

  // Drain outstanding results and let the block settle
  task automatic wait_idle();
    in_req.valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // APB write: setup then access; upper bits are ignored by the register
  task automatic write_reg(input logic [AddrW-1:0] idx, input logic [6:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= {25'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegBoardRows) rows_limit = val;
    else cols_limit = val;
  endtask

  task automatic set_board(input logic [6:0] nrows, input logic [6:0] ncols);
    wait_idle();
    write_reg(RegBoardRows, nrows);
    write_reg(RegBoardCols, ncols);
  endtask

  // Result checker
  initial begin
    placement_t exp_res, got;
    out_res.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_res.valid && out_res.ready) begin
        got = {out_res.placed, out_res.rotation, out_res.top, out_res.left,
               out_res.occupied_count};
        if (placement_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          error_count++;
        end else begin
          exp_res = placement_q.pop_front();
          if (got.placed !== exp_res.placed || got.rotation !== exp_res.rotation ||
              got.top !== exp_res.top || got.left !== exp_res.left ||
              got.occupied_count !== exp_res.occupied_count) begin
            $display("%0t: placement mismatch expected %p actual %p", $time, exp_res, got);
            error_count++;
          end
        end
      end
      if (long_hold) begin
        long_hold = 1'b0;
        out_res.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        out_res.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_res.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) quiet = 0;
      else quiet++;
      if (quiet > WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed_shapes();
    send_shape(5'd1, 5'd1, 3, 0);
    send_shape(5'd16, 5'd16, 3, 0);
    send_shape(5'd0, 5'd0, 2, 0);
    send_shape(5'd31, 5'd31, 3, 2);
    send_shape(5'd2, 5'd3, 3, 0);
    send_shape(5'd4, 5'd4, 0, 0);
    send_shape(5'd3, 5'd17, 2, 0);
  endtask

  task automatic test_board_limits();
    // vertical bar on a single row only fits turned
    set_board(7'd1, 7'd64);
    send_shape(5'd3, 5'd1, 3, 0);
    send_shape(5'd2, 5'd2, 3, 0);
    set_board(7'd64, 7'd1);
    send_shape(5'd1, 5'd4, 3, 0);
    set_board(7'd0, 7'd0);
    send_shape(5'd1, 5'd1, 3, 0);
    send_shape(5'd0, 5'd0, 1, 0);
    set_board(7'd127, 7'd127);
    send_shape(5'd2, 5'd5, 2, 0);
    send_shape(5'd1, 5'd16, 3, 0);
  endtask

  task automatic test_random_fill();
    int target;
    for (int p = 0; p < 9; p++) begin
      case (p % 3)
        0: set_board(7'($urandom_range(2, 12)), 7'($urandom_range(2, 12)));
        1: set_board(7'd1, 7'($urandom_range(4, 20)));
        default: set_board(7'($urandom_range(4, 20)), 7'($urandom_range(1, 3)));
      endcase
      target = rows_sent + 90;
      while (rows_sent < target) send_random_shape(4);
    end
    set_board(7'd64, 7'd64);
    repeat (15) send_random_shape(3);
  endtask

  task automatic test_backpressure();
    set_board(7'd6, 7'd6);
    idle_en   = 1'b0;
    long_hold = 1'b1;
    repeat (40) send_shape(5'd1, 5'd1, 1, 0);
    idle_en = 1'b1;
  endtask

  task automatic test_quiet_tail();
    set_board(7'd10, 7'd10);
    idle_en = 1'b0;
    repeat (40) send_random_shape(3);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_req.valid <= 1'b0;
    in_req.shape_height <= '0;
    in_req.shape_width <= '0;
    in_req.row_bits <= '0;
    in_req.row_last <= 1'b0;
    for (int r = 0; r < BoardSize; r++) occ_map[r] = '0;
    for (int r = 0; r < ShapeSize; r++) mask_rows[r] = '0;
    next_row = 0;
    cells_used = '0;
    rows_limit = 64;
    cols_limit = 64;
    error_count = 0;
    rows_sent = 0;
    idle_en = 1'b1;
    long_hold = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_shapes();
    test_board_limits();
    test_random_fill();
    test_backpressure();
    test_quiet_tail();

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
